// ===== rtl/core/ois_pkg.sv =====
// Shared types, constants and helpers for the ordered integer set.
// Used by the channel interfaces and every module of the block; depends on nothing.
package ois_pkg;

  // Default size of the value range 1 to SET_SIZE.
  localparam int DEFAULT_SET_SIZE = 128;

  // Width of the value, answer and member count fields.
  localparam int VAL_W = 8;

  // Largest value that an 8-bit field can carry.
  localparam int VAL_MAX = 255;

  // Operation codes carried in the func field.
  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0,
    FUNC_ERASE  = 3'd1,
    FUNC_LOWER  = 3'd2,
    FUNC_SUCC   = 3'd3,
    FUNC_PRED   = 3'd4,
    FUNC_CLEAR  = 3'd5
  } func_t;

  // Update command from the top level to the membership store.
  typedef struct packed {
    logic             insert;
    logic             erase;
    logic             clear;
    logic [VAL_W-1:0] value;
  } upd_t;

  // Only values up to 255 can ever be members, so the store never needs more slots.
  function automatic int member_slots(input int set_size);
    return (set_size < VAL_MAX) ? set_size : VAL_MAX;
  endfunction

endpackage

// ===== rtl/core/ois_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on ois_pkg for the field widths.
interface ois_req_if import ois_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       func;
  logic [VAL_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface ois_rsp_if import ois_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] answer;
  logic [VAL_W-1:0] member_total;
  logic             was_member;
  logic             bad_value;

  modport source (output valid, output answer, output member_total, output was_member,
                  output bad_value, input ready);
  modport sink   (input valid, input answer, input member_total, input was_member,
                  input bad_value, output ready);
endinterface

// ===== rtl/core/ois_search.sv =====
// Combinational query logic: masked priority encodes over the membership bits.
// Depends on ois_pkg.
module ois_search import ois_pkg::*; #(
  parameter int SET_SIZE = DEFAULT_SET_SIZE
) (
  input  logic [member_slots(SET_SIZE)-1:0] bits,
  input  logic [2:0]                        func,
  input  logic [VAL_W-1:0]                  value,
  output logic [VAL_W-1:0]                  answer,
  output logic                              was_member,
  output logic                              bad_value
);

  localparam int MEM_N = member_slots(SET_SIZE);
  localparam int IDX_W = (MEM_N > 1) ? $clog2(MEM_N) : 1;
  localparam logic [VAL_W-1:0] NONE_HIGH = VAL_W'(SET_SIZE + 1);
  localparam logic [VAL_W-1:0] NONE_LOW  = '0;

  // Bit j of the store stands for value j+1.
  // The value of the lowest set bit of a mask, the mask assumed nonzero.
  function automatic logic [VAL_W-1:0] lowest_value(input logic [MEM_N-1:0] m);
    logic [MEM_N-1:0] iso;
    logic [VAL_W-1:0] v;
    iso = m & (~m + 1'b1);
    v = '0;
    for (int j = 0; j < MEM_N; j++) begin
      if (iso[j]) v = v | VAL_W'(j + 1);
    end
    return v;
  endfunction

  logic [MEM_N-1:0] lb_mask, sc_mask, pr_mask;
  logic [MEM_N-1:0] lb_hits, sc_hits, pr_hits, pr_rev;
  logic [MEM_N-1:0] pr_iso;
  logic [VAL_W-1:0] lb_val, sc_val, pr_val;
  logic [VAL_W-1:0] value_m1;
  logic             bad;
  logic             was;

  // Range masks for the three queries.
  always_comb begin
    for (int j = 0; j < MEM_N; j++) begin
      lb_mask[j] = (j + 1) >= int'(value);
      sc_mask[j] = (j + 1) > int'(value);
      pr_mask[j] = (j + 1) < int'(value);
    end
  end

  assign lb_hits = bits & lb_mask;
  assign sc_hits = bits & sc_mask;
  assign pr_hits = bits & pr_mask;

  assign lb_val = lowest_value(lb_hits);
  assign sc_val = lowest_value(sc_hits);

  // The largest member below the value: reverse the bits and take the lowest.
  always_comb begin
    for (int j = 0; j < MEM_N; j++) begin
      pr_rev[j] = pr_hits[MEM_N-1-j];
    end
    pr_iso = pr_rev & (~pr_rev + 1'b1);
    pr_val = '0;
    for (int j = 0; j < MEM_N; j++) begin
      if (pr_iso[j]) pr_val = pr_val | VAL_W'(MEM_N - j);
    end
  end

  // Range check and membership lookup.
  assign bad      = (value == '0) || (int'(value) > SET_SIZE);
  assign value_m1 = value - VAL_W'(1);
  assign was      = !bad && bits[value_m1[IDX_W-1:0]];

  // Pick the answer by operation.
  always_comb begin
    answer     = value;
    was_member = was;
    bad_value  = bad;
    case (func)
      FUNC_LOWER: answer = (|lb_hits) ? lb_val : NONE_HIGH;
      FUNC_SUCC:  answer = (|sc_hits) ? sc_val : NONE_HIGH;
      FUNC_PRED:  answer = (|pr_hits) ? pr_val : NONE_LOW;
      FUNC_CLEAR: begin
        was_member = 1'b0;
        bad_value  = 1'b0;
      end
      default: answer = value;
    endcase
  end

endmodule

// ===== rtl/core/ois_store.sv =====
// Membership bits and member count, with insert, erase and clear updates.
// Depends on ois_pkg.
module ois_store import ois_pkg::*; #(
  parameter int SET_SIZE = DEFAULT_SET_SIZE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  upd_t                              upd,
  output logic [member_slots(SET_SIZE)-1:0] bits,
  output logic [VAL_W-1:0]                  count_next
);

  localparam int MEM_N = member_slots(SET_SIZE);
  localparam int IDX_W = (MEM_N > 1) ? $clog2(MEM_N) : 1;

  logic [MEM_N-1:0] bits_next;
  logic [VAL_W-1:0] count;
  logic [VAL_W-1:0] slot;

  // Bit j stands for value j+1; updates only come for values in range.
  assign slot = upd.value - VAL_W'(1);

  // Next state for the bits and the count.
  always_comb begin
    bits_next  = bits;
    count_next = count;
    if (en) begin
      if (upd.clear) begin
        bits_next  = '0;
        count_next = '0;
      end else if (upd.insert) begin
        bits_next[slot[IDX_W-1:0]] = 1'b1;
        count_next = count + VAL_W'(1);
      end else if (upd.erase) begin
        bits_next[slot[IDX_W-1:0]] = 1'b0;
        count_next = count - VAL_W'(1);
      end
    end
  end

  // Reset empties the set.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits  <= '0;
      count <= '0;
    end else begin
      bits  <= bits_next;
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/ordered_integer_set.sv =====
// Ordered integer set over the values 1 to SET_SIZE, with order queries.
// Depends on ois_pkg, ois_if, ois_search and ois_store.
//
// Usage: each request beat on req carries func (insert, erase, lower bound,
// successor, predecessor, clear) and value. Exactly one response beat on rsp
// follows each request, in order, with answer, member_total, was_member and
// bad_value. Updates echo the value in answer; a query with no qualifying
// member answers SET_SIZE+1 (lower bound, successor) or 0 (predecessor).
// Path: an accepted request sits in the input register, is processed against
// the membership bits from there and is loaded into the result register that
// drives rsp; a stall on rsp can hold it in either register.
// Throughput: one request per cycle, sustained while rsp is not held off;
// the membership update and the result register load happen at the same
// edge, so the next request always sees the set as left by the one before.
// Stall: while rsp is held off, the result register keeps its beat and the
// input register keeps the next request; req then deasserts ready.
// Reset (rst, synchronous): the set is empty, the count is zero and both
// registers are empty.
module ordered_integer_set import ois_pkg::*; #(
  parameter int SET_SIZE = DEFAULT_SET_SIZE
) (
  input logic       clk,
  input logic       rst,
  ois_req_if.sink   req,
  ois_rsp_if.source rsp
);

  localparam int MEM_N = member_slots(SET_SIZE);

  // Input register.
  logic             stage_valid;
  logic [2:0]       stage_func;
  logic [VAL_W-1:0] stage_value;

  // Result register.
  logic             rsp_valid;
  logic [VAL_W-1:0] rsp_answer;
  logic [VAL_W-1:0] rsp_total;
  logic             rsp_was;
  logic             rsp_bad;

  logic             advance;
  logic             work;
  logic [MEM_N-1:0] bits;
  logic [VAL_W-1:0] count_next;
  logic [VAL_W-1:0] answer;
  logic             was_member;
  logic             bad_value;
  upd_t             upd;

  // The result register drains or is empty: the pipeline moves.
  assign advance   = !rsp_valid || rsp.ready;
  assign req.ready = !stage_valid || advance;
  assign work      = stage_valid && advance;

  ois_search #(.SET_SIZE(SET_SIZE)) u_search (
    .bits       (bits),
    .func       (stage_func),
    .value      (stage_value),
    .answer     (answer),
    .was_member (was_member),
    .bad_value  (bad_value)
  );

  // Decode the update for the store.
  always_comb begin
    upd.insert = (stage_func == FUNC_INSERT) && !bad_value && !was_member;
    upd.erase  = (stage_func == FUNC_ERASE) && was_member;
    upd.clear  = (stage_func == FUNC_CLEAR);
    upd.value  = stage_value;
  end

  ois_store #(.SET_SIZE(SET_SIZE)) u_store (
    .clk        (clk),
    .rst        (rst),
    .en         (work),
    .upd        (upd),
    .bits       (bits),
    .count_next (count_next)
  );

  // Input register control and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      stage_func  <= req.func;
      stage_value <= req.value;
    end
  end

  // Result register control and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      rsp_answer <= answer;
      rsp_total  <= count_next;
      rsp_was    <= was_member;
      rsp_bad    <= bad_value;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.answer       = rsp_answer;
  assign rsp.member_total = rsp_total;
  assign rsp.was_member   = rsp_was;
  assign rsp.bad_value    = rsp_bad;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ordered_integer_set: directed table, then random set traffic.
// Depends on ois_pkg, the ois_req_if / ois_rsp_if channels and the ordered_integer_set RTL.
module testbench;
  import ois_pkg::*;

  localparam int SET_SIZE = DEFAULT_SET_SIZE;
  localparam logic [VAL_W-1:0] NONE_ABOVE = VAL_W'(SET_SIZE + 1);
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
  localparam int RANDOM_OPS = 1900;
  localparam int SEGMENT_OPS = 200;
  localparam int QUIET_TAIL = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // Traffic mixes for the random part.
  localparam int MIX_FILL = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN = 2;

  typedef struct packed {
    logic [VAL_W-1:0] answer;
    logic [VAL_W-1:0] member_total;
    logic             was_member;
    logic             bad_value;
  } set_reply_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [VAL_W-1:0] value;
    logic             fixed;
    set_reply_t       reply;
  } op_row_t;

  localparam set_reply_t NO_REPLY = '0;

  logic clk = 1'b0;
  logic rst;

  ois_req_if req ();
  ois_rsp_if rsp ();

  ordered_integer_set #(.SET_SIZE(SET_SIZE)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  // Shadow copy of the set, advanced once per accepted request beat.
  bit [SET_SIZE:1] members;
  int              member_cnt;
  set_reply_t      replies_due[$];
  int              mismatches = 0;
  bit              send_idle_on;
  bit              rsp_stall_on;
  int              stall_left;
  int              quiet_cycles;

  wire req_beat = req.valid & req.ready;
  wire rsp_beat = rsp.valid & rsp.ready;

  // Directed cases: boundaries, every operation, out-of-range values, clear.
  // Rows with fixed set use the typed reply; the rest come from the shadow set.
  op_row_t directed_ops [0:24] = '{
    '{FUNC_PRED,    8'd0,   1'b1, '{8'd0,       8'd0, 1'b0, 1'b1}},
    '{FUNC_LOWER,   8'd1,   1'b1, '{NONE_ABOVE, 8'd0, 1'b0, 1'b0}},
    '{FUNC_SUCC,    8'd255, 1'b1, '{NONE_ABOVE, 8'd0, 1'b0, 1'b1}},
    '{FUNC_INSERT,  8'd0,   1'b1, '{8'd0,       8'd0, 1'b0, 1'b1}},
    '{FUNC_INSERT,  8'd129, 1'b1, '{8'd129,     8'd0, 1'b0, 1'b1}},
    '{FUNC_INSERT,  8'd255, 1'b1, '{8'd255,     8'd0, 1'b0, 1'b1}},
    '{FUNC_INSERT,  8'd1,   1'b1, '{8'd1,       8'd1, 1'b0, 1'b0}},
    '{FUNC_INSERT,  8'd128, 1'b1, '{8'd128,     8'd2, 1'b0, 1'b0}},
    '{FUNC_INSERT,  8'd128, 1'b1, '{8'd128,     8'd2, 1'b1, 1'b0}},
    '{FUNC_INSERT,  8'd64,  1'b0, NO_REPLY},
    '{FUNC_LOWER,   8'd0,   1'b0, NO_REPLY},
    '{FUNC_SUCC,    8'd0,   1'b0, NO_REPLY},
    '{FUNC_PRED,    8'd255, 1'b0, NO_REPLY},
    '{FUNC_LOWER,   8'd64,  1'b0, NO_REPLY},
    '{FUNC_SUCC,    8'd64,  1'b0, NO_REPLY},
    '{FUNC_PRED,    8'd64,  1'b0, NO_REPLY},
    '{FUNC_SUCC,    8'd128, 1'b0, NO_REPLY},
    '{FUNC_PRED,    8'd1,   1'b0, NO_REPLY},
    '{FUNC_ERASE,   8'd200, 1'b1, '{8'd200,     8'd3, 1'b0, 1'b1}},
    '{FUNC_ERASE,   8'd5,   1'b0, NO_REPLY},
    '{FUNC_ERASE,   8'd64,  1'b0, NO_REPLY},
    '{FUNC_SPARE_6, 8'd128, 1'b0, NO_REPLY},
    '{FUNC_SPARE_7, 8'd0,   1'b0, NO_REPLY},
    '{FUNC_CLEAR,   8'd255, 1'b1, '{8'd255,     8'd0, 1'b0, 1'b0}},
    '{FUNC_LOWER,   8'd1,   1'b1, '{NONE_ABOVE, 8'd0, 1'b0, 1'b0}}
  };

  // Smallest member at or above a bound, or the none-above marker.
  function automatic int lowest_from(input int bound);
    for (int i = (bound < 1) ? 1 : bound; i <= SET_SIZE; i++)
      if (members[i]) return i;
    return SET_SIZE + 1;
  endfunction

  // Applies one operation to the shadow set and returns the reply it should produce.
  function automatic set_reply_t apply_op(input logic [2:0] op, input logic [VAL_W-1:0] v);
    set_reply_t r;
    int         val;
    int         ans;
    int         start;
    bit         bad;
    bit         was;
    val = v;
    bad = (val < 1) || (val > SET_SIZE);
    was = bad ? 1'b0 : members[val];
    ans = val;
    case (op)
      FUNC_INSERT: if (!bad && !was) begin
        members[val] = 1'b1;
        member_cnt++;
      end
      FUNC_ERASE: if (!bad && was) begin
        members[val] = 1'b0;
        member_cnt--;
      end
      FUNC_LOWER: ans = lowest_from(val);
      FUNC_SUCC:  ans = lowest_from(val + 1);
      FUNC_PRED: begin
        ans = 0;
        start = (val > SET_SIZE) ? SET_SIZE : val - 1;
        for (int i = start; i >= 1 && ans == 0; i--)
          if (members[i]) ans = i;
      end
      FUNC_CLEAR: begin
        members = '0;
        member_cnt = 0;
        was = 1'b0;
        bad = 1'b0;
      end
      default: ;
    endcase
    r.answer = VAL_W'(ans);
    r.member_total = VAL_W'(member_cnt);
    r.was_member = was;
    r.bad_value = bad;
    return r;
  endfunction

  // Presents one request beat and holds it until it is taken.
  task automatic send_op(input logic [2:0] op, input logic [VAL_W-1:0] v,
                         input bit fixed, input set_reply_t typed_reply);
    set_reply_t predicted;
    req.valid <= 1'b1;
    req.func  <= op;
    req.value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = apply_op(op, v);
    replies_due.push_back(fixed ? typed_reply : predicted);
  endtask

  // Occasionally drops valid for a burst of cycles.
  task automatic sender_gap();
    if (send_idle_on && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Response side: random stall bursts on ready.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
      rsp.ready <= 1'b0;
      stall_left <= $urandom_range(1, 17) - 1;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Each response beat is checked against the oldest pending reply.
  always @(posedge clk) begin
    set_reply_t want;
    if (!rst && rsp_beat) begin
      if (replies_due.size() == 0) begin
        $display("%0t: response beat with nothing pending, answer %0d", $time, rsp.answer);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        check_field("answer", want.answer, rsp.answer);
        check_field("member_total", want.member_total, rsp.member_total);
        check_field("was_member", want.was_member, rsp.was_member);
        check_field("bad_value", want.bad_value, rsp.bad_value);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || req_beat || rsp_beat) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ordered_integer_set regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int         mix;
    int         pick;
    logic [2:0] op;
    logic [7:0] val;

    rst = 1'b1;
    req.valid = 1'b0;
    req.func = FUNC_INSERT;
    req.value = '0;
    members = '0;
    member_cnt = 0;
    send_idle_on = 1'b1;
    rsp_stall_on = 1'b1;
    mix = MIX_FILL;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed_ops[i]) begin
      sender_gap();
      send_op(directed_ops[i].func, directed_ops[i].value, directed_ops[i].fixed,
              directed_ops[i].reply);
    end

    // Random traffic in segments that fill, drain or churn the set.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % SEGMENT_OPS == 0) begin
        mix = (n == 0) ? MIX_FILL : $urandom_range(MIX_FILL, MIX_EVEN);
        send_idle_on = ($urandom_range(0, 3) != 0);
        rsp_stall_on <= ($urandom_range(0, 3) != 0);
      end
      // The closing stretch runs with no idling on either side.
      if (n >= RANDOM_OPS - QUIET_TAIL) begin
        send_idle_on = 1'b0;
        rsp_stall_on <= 1'b0;
      end
      // Hold off once until the block has drained completely.
      if (n == RANDOM_OPS / 2) begin
        req.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
      end
      sender_gap();

      pick = $urandom_range(0, 99);
      if (pick < 1) op = FUNC_CLEAR;
      else if (pick < 3) op = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      else if (pick < 33) op = 3'($urandom_range(FUNC_LOWER, FUNC_PRED));
      else if (mix == MIX_FILL) op = (pick < 83) ? FUNC_INSERT : FUNC_ERASE;
      else if (mix == MIX_DRAIN) op = (pick < 83) ? FUNC_ERASE : FUNC_INSERT;
      else op = (pick < 66) ? FUNC_INSERT : FUNC_ERASE;

      pick = $urandom_range(0, 19);
      if (pick == 0) val = 8'd0;
      else if (pick == 1) val = 8'($urandom_range(SET_SIZE + 1, VAL_MAX));
      else if (pick == 2) val = $urandom_range(0, 1) ? 8'd1 : 8'(SET_SIZE);
      else val = 8'($urandom_range(1, SET_SIZE));

      send_op(op, val, 1'b0, NO_REPLY);
    end
    req.valid <= 1'b0;

    // Drain, then wait out any stray beat.
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ordered_integer_set regression: pass");
    end else begin
      $display("ordered_integer_set regression: fail");
    end
    $finish;
  end

endmodule
